// File: rtl/sha256s_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
package sha256s_pkg;

    typedef logic [31:0] word_t;

    // Round variables a..h, index 0 is a.
    typedef logic [7:0][31:0] vars_t;

    // Schedule words that one round sees: W[t-16], W[t-15], W[t-7], W[t-2].
    typedef struct packed {
        word_t w16;
        word_t w15;
        word_t w7;
        word_t w2;
    } sched_in_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_PRE0,
        S_PRE1,
        S_ROUND,
        S_FIN,
        S_OUT
    } state_t;

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t round_k(input logic [5:0] idx);
        return ROUND_K[idx];
    endfunction

    function automatic word_t init_h(input logic [2:0] idx);
        return INIT_H[idx];
    endfunction

    function automatic vars_t init_vars();
        vars_t v;
        for (int j = 0; j < 8; j++) begin
            v[j] = INIT_H[j];
        end
        return v;
    endfunction

    function automatic word_t bsig0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t bsig1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t ssig0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

// File: rtl/sha256s_round.sv
// One SHA-256 round with the message schedule expansion for that round.
module sha256s_round import sha256s_pkg::*; (
    input  vars_t     v_in,
    input  sched_in_t sched,
    input  logic [5:0] rnd,
    output vars_t     v_out,
    output word_t     w_out
);

    word_t w_exp;
    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;

    // The first sixteen rounds take the block words as they are.
    assign w_exp = sched.w16 + ssig0(sched.w15) + sched.w7 + ssig1(sched.w2);
    assign w_out = (rnd[5:4] == 2'b00) ? sched.w16 : w_exp;

    assign ch  = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    assign maj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    assign t1  = v_in[7] + bsig1(v_in[4]) + ch + round_k(rnd) + w_out;
    assign t2  = bsig0(v_in[0]) + maj;

    always_comb begin
        v_out[0] = t1 + t2;
        v_out[1] = v_in[0];
        v_out[2] = v_in[1];
        v_out[3] = v_in[2];
        v_out[4] = v_in[3] + t1;
        v_out[5] = v_in[4];
        v_out[6] = v_in[5];
        v_out[7] = v_in[6];
    end

endmodule

// File: rtl/sha256_stream_hash.sv
// Top level of the SHA-256 stream hasher: byte input, eight-word digest output.
//
// The block hashes a message that arrives one byte per input word and returns
// the SHA-256 digest as eight output words, the most significant first. Each
// input word carries a byte in s_tdata, s_tuser set when that byte belongs to
// the message, and s_tlast set on the final word; a word with s_tuser low and
// s_tlast high closes a message without a byte, which also gives the digest of
// the empty message. Bytes are taken at one per cycle while the block is idle.
// When the 64th byte of a block arrives, the block stops taking input: the
// states S_PRE0 and S_PRE1 prefetch the schedule memory, the 64 rounds then
// run at one per cycle (the schedule memory's two read ports and the round
// adder chain set that pace), and the state S_FIN reads, adds and writes back
// the chaining value in its memory. After the final word the block writes the
// padding words into the schedule memory (one per cycle, up to sixteen),
// compresses one or two padding blocks, and then offers the eight digest
// words at one per cycle as the sink accepts them. No clearing pass is needed
// after reset: the first block of each message takes the standard initial
// hash value from constants, and the schedule memory is always written before
// it is read.
module sha256_stream_hash import sha256s_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic        m_tlast
);

    state_t state_reg, state_next;

    // Message bookkeeping.
    logic [60:0] cnt_reg;
    logic [23:0] acc_reg;          // bytes of the partial word, newest lowest
    logic        pad_pend_reg;     // final word seen, digest not yet delivered
    logic        pad_started_reg;  // first padding block has begun
    logic        len_blk_reg;      // block in flight carries the bit length
    logic        pad_first_reg;    // next padding word holds the 0x80 marker
    logic        first_blk_reg;    // chaining value is still the initial value
    logic [3:0]  pad_wi_reg;
    logic [5:0]  rnd_reg;
    logic [3:0]  fin_cnt_reg;
    logic [2:0]  out_idx_reg;

    // Round datapath.
    vars_t work_reg;
    vars_t v_round;
    word_t w_round;
    word_t wm1_reg;
    word_t wm2_reg;
    word_t prev_a_reg;
    word_t rd_a_reg;
    word_t rd_b_reg;
    word_t ch_rd_reg;
    sched_in_t sched_in;

    // Memories: the block and its rolling schedule, and the chaining value.
    word_t sched_mem [16];
    word_t chain_mem [8];

    logic       sw_en;
    logic [3:0] sw_addr;
    word_t      sw_data;
    logic [3:0] ra_addr;
    logic [3:0] rb_addr;
    logic       cw_en;

    logic       in_acc;
    logic       out_acc;
    logic       byte_in;
    logic [5:0] pos;
    logic [5:0] pos_next;
    logic       blk_full;
    logic       fin_done;
    logic       start_pad1;
    logic       start_pad2;
    logic       end_msg;
    logic [3:0] fin_prev;
    logic [2:0] fin_j;
    word_t      fin_old;
    word_t      fin_sum;
    word_t      pad_word;
    word_t      len_hi;
    word_t      len_lo;

    assign in_acc   = s_tvalid & s_tready;
    assign out_acc  = m_tvalid & m_tready;
    assign byte_in  = in_acc & s_tuser;
    assign pos      = cnt_reg[5:0];
    assign pos_next = byte_in ? pos + 6'd1 : pos;
    assign blk_full = byte_in && (pos == 6'd63);
    assign fin_done = (state_reg == S_FIN) && (fin_cnt_reg == 4'd8);
    assign end_msg  = (state_reg == S_OUT) && out_acc && (out_idx_reg == 3'd7);

    assign start_pad1 = ((state_reg == S_IDLE) && in_acc && s_tlast && !blk_full) ||
                        (fin_done && !len_blk_reg && !pad_started_reg && pad_pend_reg);
    assign start_pad2 = fin_done && !len_blk_reg && pad_started_reg;

    // Message length in bits, as the two final block words.
    assign len_hi = cnt_reg[60:29];
    assign len_lo = {cnt_reg[28:0], 3'b000};

    // The partial word closed with the 0x80 marker and zero fill.
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    pad_word = 32'h8000_0000;
            2'd1:    pad_word = {acc_reg[7:0], 24'h80_0000};
            2'd2:    pad_word = {acc_reg[15:0], 16'h8000};
            default: pad_word = {acc_reg[23:0], 8'h80};
        endcase
    end

    // Chaining update: the read of word j is registered and lands in the cycle after its address.
    assign fin_prev = fin_cnt_reg - 4'd1;
    assign fin_j    = fin_prev[2:0];
    assign fin_old  = first_blk_reg ? init_h(fin_j) : ch_rd_reg;
    assign fin_sum  = work_reg[fin_j] + fin_old;

    assign sched_in.w16 = prev_a_reg;
    assign sched_in.w15 = rd_a_reg;
    assign sched_in.w7  = rd_b_reg;
    assign sched_in.w2  = wm2_reg;

    sha256s_round u_round (
        .v_in  (work_reg),
        .sched (sched_in),
        .rnd   (rnd_reg),
        .v_out (v_round),
        .w_out (w_round)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (blk_full) begin
                        state_next = S_PRE0;
                    end else if (s_tlast) begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (pad_wi_reg == 4'd15) begin
                    state_next = S_PRE0;
                end
            end
            S_PRE0: state_next = S_PRE1;
            S_PRE1: state_next = S_ROUND;
            S_ROUND: begin
                if (rnd_reg == 6'd63) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_done) begin
                    if (len_blk_reg) begin
                        state_next = S_OUT;
                    end else if (pad_started_reg || pad_pend_reg) begin
                        state_next = S_PAD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (end_msg) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and memory port controls.
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        sw_en    = 1'b0;
        sw_addr  = pos[5:2];
        sw_data  = {acc_reg, s_tdata};
        ra_addr  = 4'd0;
        rb_addr  = 4'd0;
        cw_en    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                sw_en    = byte_in && (pos[1:0] == 2'd3);
            end
            S_PAD: begin
                sw_en   = 1'b1;
                sw_addr = pad_wi_reg;
                if (pad_first_reg) begin
                    sw_data = pad_word;
                end else if (len_blk_reg && (pad_wi_reg == 4'd14)) begin
                    sw_data = len_hi;
                end else if (len_blk_reg && (pad_wi_reg == 4'd15)) begin
                    sw_data = len_lo;
                end else begin
                    sw_data = '0;
                end
            end
            S_PRE0: begin
                ra_addr = 4'd0;
            end
            S_PRE1: begin
                ra_addr = 4'd1;
                rb_addr = 4'd9;
            end
            S_ROUND: begin
                sw_en   = 1'b1;
                sw_addr = rnd_reg[3:0];
                sw_data = w_round;
                ra_addr = rnd_reg[3:0] + 4'd2;
                rb_addr = rnd_reg[3:0] + 4'd10;
            end
            S_FIN: begin
                cw_en = (fin_cnt_reg != 4'd0);
            end
            S_OUT: begin
                m_tvalid = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign m_tdata = {5'b00000, out_idx_reg, work_reg[out_idx_reg]};
    assign m_tlast = (out_idx_reg == 3'd7);

    // Schedule memory: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (sw_en) begin
            sched_mem[sw_addr] <= sw_data;
        end
        rd_a_reg <= sched_mem[ra_addr];
        rd_b_reg <= sched_mem[rb_addr];
    end

    // Chaining value memory: write word j-1 while word j is read.
    always_ff @(posedge aclk) begin
        if (cw_en) begin
            chain_mem[fin_j] <= fin_sum;
        end
        ch_rd_reg <= chain_mem[fin_cnt_reg[2:0]];
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        prev_a_reg <= rd_a_reg;
        if (byte_in) begin
            acc_reg <= {acc_reg[15:0], s_tdata};
        end
        if (state_reg == S_ROUND) begin
            wm1_reg <= w_round;
            wm2_reg <= wm1_reg;
        end
    end

    // Control state and round variables.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            pad_pend_reg    <= 1'b0;
            pad_started_reg <= 1'b0;
            len_blk_reg     <= 1'b0;
            pad_first_reg   <= 1'b0;
            first_blk_reg   <= 1'b1;
            pad_wi_reg      <= '0;
            rnd_reg         <= '0;
            fin_cnt_reg     <= '0;
            out_idx_reg     <= '0;
            work_reg        <= init_vars();
        end else begin
            state_reg <= state_next;

            if (byte_in) begin
                cnt_reg <= cnt_reg + 61'd1;
            end
            if ((state_reg == S_IDLE) && in_acc && s_tlast) begin
                pad_pend_reg <= 1'b1;
            end

            if (start_pad1) begin
                pad_wi_reg      <= pos_next[5:2];
                pad_first_reg   <= 1'b1;
                len_blk_reg     <= (pos_next[5:3] != 3'b111);
                pad_started_reg <= 1'b1;
            end else if (start_pad2) begin
                pad_wi_reg    <= 4'd0;
                pad_first_reg <= 1'b0;
                len_blk_reg   <= 1'b1;
            end else if (state_reg == S_PAD) begin
                pad_wi_reg    <= pad_wi_reg + 4'd1;
                pad_first_reg <= 1'b0;
            end

            if (state_reg == S_PRE0) begin
                rnd_reg <= '0;
            end else if (state_reg == S_ROUND) begin
                rnd_reg <= rnd_reg + 6'd1;
                work_reg <= v_round;
            end

            if ((state_reg == S_ROUND) && (rnd_reg == 6'd63)) begin
                fin_cnt_reg <= '0;
            end else if (state_reg == S_FIN) begin
                fin_cnt_reg <= fin_cnt_reg + 4'd1;
                if (fin_cnt_reg != 4'd0) begin
                    work_reg[fin_j] <= fin_sum;
                end
            end

            if (fin_done) begin
                first_blk_reg <= 1'b0;
            end

            // The word index wraps from seven back to zero on the last word.
            if ((state_reg == S_OUT) && out_acc) begin
                out_idx_reg <= out_idx_reg + 3'd1;
            end

            // Delivered the last digest word: back to the state after reset.
            if (end_msg) begin
                cnt_reg         <= '0;
                pad_pend_reg    <= 1'b0;
                pad_started_reg <= 1'b0;
                len_blk_reg     <= 1'b0;
                first_blk_reg   <= 1'b1;
                work_reg        <= init_vars();
            end
        end
    end

    // A round never writes a schedule entry that is being fetched for a later round.
    a_sched_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROUND) |-> (sw_addr != ra_addr && sw_addr != rb_addr))
        else $error("schedule write collides with a prefetch read");

    // Input and output are never open in the same cycle.
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while digest is offered");

    // The chaining update starts only after the sixty-fourth round.
    a_fin_after_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && $past(state_reg) == S_ROUND) |-> $past(rnd_reg) == 6'd63)
        else $error("chaining update began before the last round");

    // After the last digest word the next message starts from the initial value.
    a_msg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && m_tlast) |=> (first_blk_reg && cnt_reg == 61'd0 && state_reg == S_IDLE))
        else $error("message state not restored after the digest");

endmodule

// File: bench/tb_sha256_stream_hash.sv
// Self-checking bench for the SHA-256 stream hasher, with an in-bench hash model and random stalls.
module tb_sha256_stream_hash;
    timeunit 1ns;
    timeprecision 1ps;

    // Round constants and initial hash value, kept here so that a wrong
    // table in the design cannot hide behind a shared copy.
    localparam logic [31:0] RND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // One expected digest word as it should leave the result channel.
    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  index;
        logic        is_tail;
    } digest_entry_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte[7:0]
    logic        s_tuser;   // byte_valid
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // digest_word[31:0], word_index[34:32], zero fill
    logic        m_tlast;

    // Running hash of the message in flight: chaining value, the partly
    // filled 64-byte block and the byte count (61 bits, as in the design).
    logic [31:0] hash_state [8];
    logic [7:0]  block_buf [64];
    logic [60:0] msg_bytes;

    digest_entry_t pending_digest [$];

    int n_errors;
    int n_words;
    int n_messages;
    int n_bytes;

    // When set, the matching side of the bench runs without any idle cycles.
    bit src_steady;
    bit snk_steady;

    sha256_stream_hash dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One full compression of block_buf into hash_state. The schedule is
    // expanded to all 64 words up front rather than kept as a rolling window.
    task automatic sha_compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int r = 0; r < 64; r++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + RND_CONST[r] + w[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic sha_restart();
        for (int j = 0; j < 8; j++) begin
            hash_state[j] = START_HASH[j];
        end
        for (int j = 0; j < 64; j++) begin
            block_buf[j] = 8'h00;
        end
        msg_bytes = '0;
    endtask

    // Takes one accepted input word. A byte goes into the block first; a
    // closing word then pads, compresses one or two final blocks and queues
    // the eight digest words.
    task automatic sha_absorb(input logic [7:0] b, input logic has_byte, input logic fin);
        logic [5:0]    pos;
        logic [63:0]   bit_len;
        digest_entry_t ent;
        if (has_byte) begin
            block_buf[msg_bytes[5:0]] = b;
            msg_bytes = msg_bytes + 61'd1;
            n_bytes++;
            if (msg_bytes[5:0] == 6'd0) begin
                sha_compress_block();
            end
        end
        if (fin) begin
            pos = msg_bytes[5:0];
            block_buf[pos] = 8'h80;
            for (int j = pos + 1; j < 64; j++) begin
                block_buf[j] = 8'h00;
            end
            // No room left for the length field: this block goes out as is
            // and the length travels in an extra all-zero block.
            if (pos >= 6'd56) begin
                sha_compress_block();
                for (int j = 0; j < 64; j++) begin
                    block_buf[j] = 8'h00;
                end
            end
            bit_len = {msg_bytes, 3'b000};
            for (int j = 0; j < 8; j++) begin
                block_buf[56 + j] = bit_len[63 - 8*j -: 8];
            end
            sha_compress_block();
            for (int j = 0; j < 8; j++) begin
                ent.value   = hash_state[j];
                ent.index   = 3'(j);
                ent.is_tail = (j == 7);
                pending_digest.push_back(ent);
            end
            n_messages++;
            sha_restart();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0.1f ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        n_errors++;
    endtask

    // Sends one word on the input channel. It is entered and left at a
    // falling edge; the word is held until the rising edge that accepts it.
    task automatic send_word(input logic [7:0] b, input logic has_byte, input logic fin);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = has_byte;
        s_tlast  = fin;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        @(negedge aclk);
    endtask

    // The hash of the empty message comes from a closing word without a
    // byte; its data byte must be ignored.
    task automatic test_empty_message();
        send_word(8'h5a, 1'b0, 1'b1);
    endtask

    // Three bytes with the final flag on the last byte itself.
    task automatic test_byte_with_last();
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
    endtask

    // Words without a byte, each with a nonzero data field, scattered
    // through a message that is then closed by a word without a byte.
    task automatic test_words_without_byte();
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'ha5, 1'b0, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h3c, 1'b0, 1'b0);
        send_word(8'hc3, 1'b0, 1'b1);
    endtask

    // Byte extremes, sent back to back with no stalls on either side.
    task automatic test_byte_extremes();
        src_steady = 1'b1;
        snk_steady = 1'b1;
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h7f, 1'b1, 1'b0);
        send_word(8'h01, 1'b1, 1'b0);
        send_word(8'hfe, 1'b1, 1'b1);
        src_steady = 1'b0;
        snk_steady = 1'b0;
    endtask

    // Random messages. Lengths are mostly short, with a good share right at
    // the block and padding boundaries and some spanning two blocks.
    // Words without a byte are sprinkled in as noise and do not count.
    task automatic test_random_messages(input int budget);
        int sent;
        int len;
        int pick;
        bit tail_on_byte;
        int boundary [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 5);
            if (pick == 0) begin
                len = boundary[$urandom_range(0, 8)];
            end else if (pick == 1) begin
                len = $urandom_range(21, 100);
            end else begin
                len = $urandom_range(0, 20);
            end
            tail_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            src_steady = ($urandom_range(0, 3) == 0);
            snk_steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_word(8'($urandom), 1'b0, 1'b0);
                end
                send_word(8'($urandom), 1'b1, tail_on_byte && (i == len - 1));
                sent++;
            end
            if (!tail_on_byte) begin
                send_word(8'($urandom), 1'b0, 1'b1);
                sent++;
            end
        end
        src_steady = 1'b0;
        snk_steady = 1'b0;
    endtask

    // Input monitor: every accepted word feeds the hash model.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sha_absorb(s_tdata, s_tuser, s_tlast);
        end
    end

    // Result checker: each accepted digest word against the oldest expectation.
    always @(posedge aclk) begin : check_digest
        digest_entry_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_digest.size() == 0) begin
                report_mismatch("digest word with none pending", m_tdata[31:0], 32'h0);
            end else begin
                exp_w = pending_digest.pop_front();
                n_words++;
                if (m_tdata[31:0] !== exp_w.value) begin
                    report_mismatch("digest_word", m_tdata[31:0], exp_w.value);
                end
                if (m_tdata[34:32] !== exp_w.index) begin
                    report_mismatch("word_index", 32'(m_tdata[34:32]), 32'(exp_w.index));
                end
                if (m_tlast !== exp_w.is_tail) begin
                    report_mismatch("digest_last", 32'(m_tlast), 32'(exp_w.is_tail));
                end
                if (m_tdata[39:35] !== 5'd0) begin
                    report_mismatch("tdata fill", 32'(m_tdata[39:35]), 32'h0);
                end
            end
        end
    end

    // Result sink: before each word it draws a stall, then holds tready high
    // until a word is taken.
    initial begin : sink_side
        int stall;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            stall = snk_steady ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (m_tvalid !== 1'b1) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tuser    = 1'b0;
        s_tlast    = 1'b0;
        src_steady = 1'b0;
        snk_steady = 1'b0;
        n_errors   = 0;
        n_words    = 0;
        n_messages = 0;
        n_bytes    = 0;
        sha_restart();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        test_empty_message();
        test_byte_with_last();
        test_words_without_byte();
        test_byte_extremes();
        test_random_messages(340);
        s_tvalid = 1'b0;

        // Drain, then leave room for two compressions plus padding so that
        // any stray extra word still shows up.
        while (pending_digest.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);

        $display("Hashed %0d messages, %0d bytes, lengths spread over block and padding edges.",
                 n_messages, n_bytes);
        $display("Checked %0d digest words under random stalls on both sides, %0d mismatches.",
                 n_words, n_errors);
        if (n_errors == 0) begin
            $display("tb_sha256_stream_hash: clean");
        end else begin
            $display("tb_sha256_stream_hash: errors");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #10000000;
        $display("Run timed out with %0d digest words still pending.", pending_digest.size());
        $display("tb_sha256_stream_hash: errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sha256s_pkg.sv
rtl/sha256s_round.sv
rtl/sha256_stream_hash.sv
bench/tb_sha256_stream_hash.sv
